// ===== rtl/imu_bc_pkg.sv =====
package imu_bc_pkg;

    localparam int IN_W        = 16;
    localparam int MAG_W       = 16;
    localparam int SQ_W        = 32;
    localparam int ACC_W       = 18;
    localparam int RATE_W      = 21;
    localparam int MEAN_W      = 20;
    localparam int BIAS_W      = 24;
    localparam int KIND_W      = 2;
    localparam int LIM_W       = 30;
    localparam int FS_W        = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = LIM_W;

    localparam int CAL_SAMPLES_DEF = 256;
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1000);
    localparam logic [FS_W-1:0]  FS_RESET  = FS_W'(2000);

    // shared multiplier: (gyro*256 - bias) x full scale, or a square
    localparam int SM_A_W = BIAS_W + 1;
    localparam int SM_B_W = IN_W + 1;
    localparam int SP_W   = SM_A_W + SM_B_W;

    localparam int RATE_SHIFT = 15;
    localparam int RATE_HALF  = 16384;

    localparam int ACC_POS_LIM  = 131071;
    localparam int ACC_NEG_LIM  = 131072;
    localparam int RATE_POS_LIM = 1048575;
    localparam int RATE_NEG_LIM = 1048576;
    localparam int MEAN_MAX     = 1048575;

    localparam logic signed [ACC_W-1:0]  ACC_MAX  = ACC_W'(ACC_POS_LIM);
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = ACC_W'(-ACC_NEG_LIM);
    localparam logic signed [RATE_W-1:0] RATE_MAX = RATE_W'(RATE_POS_LIM);
    localparam logic signed [RATE_W-1:0] RATE_MIN = RATE_W'(-RATE_NEG_LIM);

    localparam int IN_TDATA_W  = 6 * IN_W;
    localparam int OUT_FIELD_W = 3 * ACC_W + 3 * RATE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PASS   = 2'd0,
        KIND_FAIL   = 2'd1,
        KIND_SAMPLE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        DIV_MEAN  = 2'd0,
        DIV_BIAS  = 2'd1,
        DIV_ACCEL = 2'd2
    } t_div_op;

    typedef enum logic [1:0] {
        SMUL_LIM = 2'd0,
        SMUL_LHS = 2'd1,
        SMUL_S2  = 2'd2
    } t_smul_op;

    typedef struct packed {
        logic     load;
        logic     sq_mul;
        logic     sq_acc;
        logic     rate_mul;
        logic     rate_store;
        logic     sqrt_go;
        logic     mag_acc;
        logic     div_go;
        logic     div_store;
        t_div_op  div_op;
        logic     smul_go;
        logic     smul_store;
        t_smul_op smul_op;
        logic     var_test;
        logic     emit_cal;
        logic     emit_run;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic running;
        logic last;
        logic sqrt_done;
        logic div_done;
        logic smul_done;
        logic mean_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/imu_bc_sqrt.sv =====
module imu_bc_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [imu_bc_pkg::SQ_W-1:0]  i_val,
    output logic                         o_done,
    output logic [imu_bc_pkg::MAG_W-1:0] o_root
);
    import imu_bc_pkg::*;

    localparam int STEPS  = SQ_W / 2;
    localparam int STEP_W = $clog2(STEPS);

    logic [SQ_W-1:0]   r_v, n_v;
    logic [SQ_W-1:0]   r_r, n_r;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [SQ_W-1:0]   bit_w;
    logic [SQ_W:0]     trial;

    // one result bit per step, trial bit walks down two places at a time
    assign bit_w = (SQ_W'(1) << (SQ_W - 2)) >> {r_step, 1'b0};
    assign trial = {1'b0, r_r} + {1'b0, bit_w};

    always_comb begin
        n_v = r_v;
        n_r = r_r >> 1;
        if ({1'b0, r_v} >= trial) begin
            n_v = r_v - trial[SQ_W-1:0];
            n_r = (r_r >> 1) + bit_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_val;
            r_r <= '0;
        end else if (r_busy) begin
            r_v <= n_v;
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[MAG_W-1:0];

endmodule

// ===== rtl/imu_bc_div.sv =====
// Rounded unsigned divide: quotient = floor((2*num + den) / (2*den)), den > 0.
module imu_bc_div #(
    parameter int NW = 33,
    parameter int DW = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    output logic            o_done,
    output logic [NW+1:0]   o_quot
);
    localparam int QW = NW + 2;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_q;
    logic [DW:0]   r_dv;
    logic [DW+1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW+1:0] trial;
    logic          take;

    assign trial = {r_rem[DW:0], r_q[QW-1]};
    assign take  = trial >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {1'b0, i_num, 1'b0} + QW'(i_den);
            r_dv  <= {i_den, 1'b0};
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= take ? (trial - {1'b0, r_dv}) : trial;
            r_q   <= {r_q[QW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/imu_bc_ctrl.sv =====
module imu_bc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  imu_bc_pkg::t_sts  i_sts,
    output imu_bc_pkg::t_cmd  o_cmd
);
    import imu_bc_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE   = 19'(1) << 0,
        S_MUL    = 19'(1) << 1,
        S_ACC    = 19'(1) << 2,
        S_SQRT   = 19'(1) << 3,
        S_SQWAIT = 19'(1) << 4,
        S_MEAN   = 19'(1) << 5,
        S_BIAS   = 19'(1) << 6,
        S_LIM    = 19'(1) << 7,
        S_LIMW   = 19'(1) << 8,
        S_LHS    = 19'(1) << 9,
        S_LHSW   = 19'(1) << 10,
        S_S2     = 19'(1) << 11,
        S_S2W    = 19'(1) << 12,
        S_TEST   = 19'(1) << 13,
        S_ACCEL  = 19'(1) << 14,
        S_ACCELW = 19'(1) << 15,
        S_RMUL   = 19'(1) << 16,
        S_RATE   = 19'(1) << 17,
        S_EMIT   = 19'(1) << 18
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        cmd     = '0;
        cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_idx    = '0;
                    n_state  = i_sts.running ? S_ACCEL : S_MUL;
                end
            end
            S_MUL: begin
                cmd.sq_mul = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                cmd.sq_acc = 1'b1;
                if (r_idx == 3'd5) begin
                    n_state = S_SQRT;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_SQRT: begin
                cmd.sqrt_go = 1'b1;
                n_state     = S_SQWAIT;
            end
            S_SQWAIT: begin
                if (i_sts.sqrt_done) begin
                    cmd.mag_acc = 1'b1;
                    n_idx       = '0;
                    n_state     = i_sts.last ? S_MEAN : S_IDLE;
                end
            end
            S_MEAN: begin
                cmd.div_op    = DIV_MEAN;
                cmd.div_store = 1'b1;
                n_state       = S_BIAS;
            end
            S_BIAS: begin
                cmd.div_op    = DIV_BIAS;
                cmd.div_store = 1'b1;
                if (r_idx == 3'd2) begin
                    n_idx   = '0;
                    n_state = S_LIM;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_BIAS;
                end
            end
            S_LIM: begin
                cmd.smul_go = 1'b1;
                cmd.smul_op = SMUL_LIM;
                n_state     = S_LIMW;
            end
            S_LIMW: begin
                cmd.smul_op = SMUL_LIM;
                if (i_sts.smul_done) begin
                    cmd.smul_store = 1'b1;
                    n_state        = S_LHS;
                end
            end
            S_LHS: begin
                cmd.smul_go = 1'b1;
                cmd.smul_op = SMUL_LHS;
                n_state     = S_LHSW;
            end
            S_LHSW: begin
                cmd.smul_op = SMUL_LHS;
                if (i_sts.smul_done) begin
                    cmd.smul_store = 1'b1;
                    n_state        = S_S2;
                end
            end
            S_S2: begin
                cmd.smul_go = 1'b1;
                cmd.smul_op = SMUL_S2;
                n_state     = S_S2W;
            end
            S_S2W: begin
                cmd.smul_op = SMUL_S2;
                if (i_sts.smul_done) begin
                    cmd.smul_store = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_TEST: begin
                cmd.var_test = 1'b1;
                if (r_idx == 3'd2) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_LHS;
                end
            end
            S_ACCEL: begin
                cmd.div_op = DIV_ACCEL;
                // zero mean: the datapath saturates by sign, skip the divide
                if (i_sts.mean_zero) begin
                    cmd.div_store = 1'b1;
                    n_state       = S_RMUL;
                end else begin
                    cmd.div_go = 1'b1;
                    n_state    = S_ACCELW;
                end
            end
            S_ACCELW: begin
                cmd.div_op = DIV_ACCEL;
                if (i_sts.div_done) begin
                    cmd.div_store = 1'b1;
                    n_state       = S_RMUL;
                end
            end
            S_RMUL: begin
                cmd.rate_mul = 1'b1;
                n_state      = S_RATE;
            end
            S_RATE: begin
                cmd.rate_store = 1'b1;
                if (r_idx == 3'd2) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_ACCEL;
                end
            end
            S_EMIT: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    cmd.emit_cal = !i_sts.running;
                    cmd.emit_run = i_sts.running;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ===== rtl/imu_bc_dp.sv =====
module imu_bc_dp #(
    parameter int CAL_SAMPLES = imu_bc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  imu_bc_pkg::t_cmd                    i_cmd,
    output imu_bc_pkg::t_sts                    o_sts,
    input  logic [imu_bc_pkg::IN_TDATA_W-1:0]   i_in_tdata,
    input  logic                                i_cfg_we,
    input  logic [imu_bc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [imu_bc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [imu_bc_pkg::OUT_TDATA_W-1:0]  o_out_tdata,
    output logic [imu_bc_pkg::KIND_W-1:0]       o_out_tuser
);
    import imu_bc_pkg::*;

    // CAL_SAMPLES is a power of two: mean and bias are rounded shifts
    localparam int N      = CAL_SAMPLES;
    localparam int LOG_N  = $clog2(N);
    localparam int CNT_W  = LOG_N;
    localparam int MSUM_W = MAG_W + LOG_N;
    localparam int RSUM_W = IN_W + LOG_N;
    localparam int RSQ_W  = 2 * IN_W - 1 + LOG_N;
    localparam int NW     = IN_W + 17;
    localparam int QW     = NW + 2;
    localparam int VW     = RSQ_W + LOG_N + 1;
    localparam int MB_W   = (RSUM_W > 2 * LOG_N + 1) ? RSUM_W : 2 * LOG_N + 1;
    localparam int N2     = N * N;
    localparam int RQ_W   = SP_W - RATE_SHIFT;
    localparam int MRND_W = MSUM_W + 5;
    localparam int BRND_W = RSUM_W + 9;

    // configuration
    logic [LIM_W-1:0] r_lim;
    logic [FS_W-1:0]  r_fs;

    // sample and single multiplier
    logic signed [IN_W-1:0] r_smp [6];
    logic signed [SP_W-1:0] r_sp;

    // calibration accumulators
    logic [SQ_W-1:0]          r_sq;
    logic [MSUM_W-1:0]        r_msum;
    logic [CNT_W-1:0]         r_count;
    logic signed [RSUM_W-1:0] r_rsum [3];
    logic [RSQ_W-1:0]         r_rsq [3];
    logic                     r_running;
    logic                     r_fail;
    logic [MEAN_W-1:0]        r_mean;
    logic signed [BIAS_W-1:0] r_bias [3];

    // bit-serial multiplier for the variance test
    logic [VW-1:0]   r_ma, r_mp, r_limn2, r_lhs, r_s2;
    logic [MB_W-1:0] r_mb;
    logic            r_mbusy;
    logic            r_mdone;

    // work and output registers
    logic signed [ACC_W-1:0]  r_wacc [3];
    logic signed [RATE_W-1:0] r_wrate [3];
    logic                     r_ovalid;
    t_kind                    r_okind;
    logic [OUT_TDATA_W-1:0]   r_odata;

    logic [1:0]              axis;
    logic signed [IN_W-1:0]  sq_op;
    logic signed [IN_W-1:0]  acc_in;
    logic signed [IN_W-1:0]  gyro_in;
    logic [RSUM_W-1:0]       abs_sum;
    logic                    sum_neg;
    logic [IN_W:0]           abs_a;
    logic signed [SM_A_W-1:0] sm_a;
    logic signed [SM_B_W-1:0] sm_b;
    logic signed [SM_A_W-1:0] rate_diff;

    logic              sqrt_done;
    logic [MAG_W-1:0]  root;
    logic [NW-1:0]     div_num;
    logic [MEAN_W-1:0] div_den;
    logic              div_done;
    logic [QW-1:0]     quot;

    logic [MRND_W-1:0] mean_rnd;
    logic [MRND_W-1:0] mean_q;
    logic [MEAN_W-1:0] mean_val;
    logic [BRND_W-1:0] bias_rnd;

    logic [VW-1:0]   sm_ain;
    logic [MB_W-1:0] sm_bin;
    logic [VW-1:0]   var_n2;

    logic [SP_W-1:0]          rate_mag;
    logic [RQ_W-1:0]          rate_q;
    logic signed [RATE_W-1:0] rate_val;
    logic signed [ACC_W-1:0]  acc_val;
    logic [BIAS_W-1:0]        bias_q;
    logic                     out_free;

    assign axis    = i_cmd.idx[1:0];
    assign sq_op   = r_smp[i_cmd.idx];
    assign acc_in  = r_smp[3'(axis)];
    assign gyro_in = r_smp[3'(axis) + 3'd3];
    assign sum_neg = r_rsum[axis][RSUM_W-1];
    assign abs_sum = sum_neg ? RSUM_W'(-r_rsum[axis]) : RSUM_W'(r_rsum[axis]);
    assign abs_a   = acc_in[IN_W-1] ? (IN_W+1)'(-{acc_in[IN_W-1], acc_in})
                                    : (IN_W+1)'({1'b0, acc_in});

    assign rate_diff = {gyro_in[IN_W-1], gyro_in, 8'b0}
                     - {r_bias[axis][BIAS_W-1], r_bias[axis]};

    always_comb begin
        if (i_cmd.rate_mul) begin
            sm_a = rate_diff;
            sm_b = {{(SM_B_W - FS_W){1'b0}}, r_fs};
        end else begin
            sm_a = {{(SM_A_W - IN_W){sq_op[IN_W-1]}}, sq_op};
            sm_b = {{(SM_B_W - IN_W){sq_op[IN_W-1]}}, sq_op};
        end
    end

    imu_bc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_go),
        .i_val   (r_sq),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    // mean and bias: add half of N, then shift by log2(N)
    assign mean_rnd = {1'b0, r_msum, 4'b0} + MRND_W'(N / 2);
    assign mean_q   = mean_rnd >> LOG_N;
    assign mean_val = (mean_q > MRND_W'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX)
                                                   : mean_q[MEAN_W-1:0];
    assign bias_rnd = {1'b0, abs_sum, 8'b0} + BRND_W'(N / 2);
    assign bias_q   = BIAS_W'(bias_rnd >> LOG_N);

    assign div_num = NW'({abs_a, 16'b0});
    assign div_den = r_mean;

    imu_bc_div #(
        .NW (NW),
        .DW (MEAN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        unique case (i_cmd.smul_op)
            SMUL_LIM: begin
                sm_ain = VW'(r_lim);
                sm_bin = MB_W'(N2);
            end
            SMUL_LHS: begin
                sm_ain = VW'(r_rsq[axis]);
                sm_bin = MB_W'(N);
            end
            SMUL_S2: begin
                sm_ain = VW'(abs_sum);
                sm_bin = MB_W'(abs_sum);
            end
            default: begin
                sm_ain = '0;
                sm_bin = '0;
            end
        endcase
    end

    assign var_n2 = (r_lhs >= r_s2) ? (r_lhs - r_s2) : '0;

    // accel: divide result with sign and saturation, or sign only at zero mean
    always_comb begin
        if (r_mean == '0) begin
            if (acc_in == '0) begin
                acc_val = '0;
            end else begin
                acc_val = acc_in[IN_W-1] ? ACC_MIN : ACC_MAX;
            end
        end else if (acc_in[IN_W-1]) begin
            acc_val = (quot > QW'(ACC_NEG_LIM)) ? ACC_MIN : -quot[ACC_W-1:0];
        end else begin
            acc_val = (quot > QW'(ACC_POS_LIM)) ? ACC_MAX : quot[ACC_W-1:0];
        end
    end

    // rate: round half away from zero over the 2^15 shift, then saturate
    assign rate_mag = r_sp[SP_W-1] ? SP_W'(-r_sp) : SP_W'(r_sp);
    assign rate_q   = RQ_W'((rate_mag + SP_W'(RATE_HALF)) >> RATE_SHIFT);
    always_comb begin
        if (r_sp[SP_W-1]) begin
            rate_val = (rate_q > RQ_W'(RATE_NEG_LIM)) ? RATE_MIN : -rate_q[RATE_W-1:0];
        end else begin
            rate_val = (rate_q > RQ_W'(RATE_POS_LIM)) ? RATE_MAX : rate_q[RATE_W-1:0];
        end
    end

    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim     <= LIM_RESET;
            r_fs      <= FS_RESET;
            r_msum    <= '0;
            r_count   <= '0;
            r_running <= 1'b0;
            r_fail    <= 1'b0;
            r_mean    <= '0;
            r_mbusy   <= 1'b0;
            r_mdone   <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_rsum[k] <= '0;
                r_rsq[k]  <= '0;
                r_bias[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GYRO_LIMIT: r_lim <= i_cfg_wdata[LIM_W-1:0];
                    CFG_FULL_SCALE: r_fs  <= i_cfg_wdata[FS_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.sq_acc && i_cmd.idx >= 3'd3) begin
                r_rsq[axis - 2'd3]  <= r_rsq[axis - 2'd3] + RSQ_W'(r_sp);
                r_rsum[axis - 2'd3] <= r_rsum[axis - 2'd3]
                                     + {{(RSUM_W - IN_W){sq_op[IN_W-1]}}, sq_op};
            end

            if (i_cmd.mag_acc) begin
                r_msum  <= r_msum + MSUM_W'(root);
                r_count <= r_count + CNT_W'(1);
            end

            if (i_cmd.div_store) begin
                unique case (i_cmd.div_op)
                    DIV_MEAN: r_mean <= mean_val;
                    DIV_BIAS: r_bias[axis] <= sum_neg ? -bias_q : bias_q;
                    default: ;
                endcase
            end

            r_mdone <= 1'b0;
            if (i_cmd.smul_go) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && r_mb == '0) begin
                r_mbusy <= 1'b0;
                r_mdone <= 1'b1;
            end

            if (i_cmd.var_test && !(var_n2 < r_limn2)) begin
                r_fail <= 1'b1;
            end

            if (i_cmd.emit_cal) begin
                r_running <= !r_fail;
                r_fail    <= 1'b0;
                r_msum    <= '0;
                r_count   <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_rsum[k] <= '0;
                    r_rsq[k]  <= '0;
                end
            end

            if (i_cmd.emit_cal || i_cmd.emit_run) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 6; k++) begin
                r_smp[k] <= i_in_tdata[k*IN_W +: IN_W];
            end
        end
        if (i_cmd.sq_mul || i_cmd.rate_mul) begin
            r_sp <= sm_a * sm_b;
        end
        if (i_cmd.sq_acc) begin
            if (i_cmd.idx == 3'd0) begin
                r_sq <= SQ_W'(r_sp);
            end else if (i_cmd.idx < 3'd3) begin
                r_sq <= r_sq + SQ_W'(r_sp);
            end
        end
        if (i_cmd.smul_go) begin
            r_ma <= sm_ain;
            r_mb <= sm_bin;
            r_mp <= '0;
        end else if (r_mbusy && r_mb != '0) begin
            if (r_mb[0]) begin
                r_mp <= r_mp + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
        if (i_cmd.smul_store) begin
            unique case (i_cmd.smul_op)
                SMUL_LIM: r_limn2 <= r_mp;
                SMUL_LHS: r_lhs   <= r_mp;
                SMUL_S2:  r_s2    <= r_mp;
                default: ;
            endcase
        end
        if (i_cmd.div_store && i_cmd.div_op == DIV_ACCEL) begin
            r_wacc[axis] <= acc_val;
        end
        if (i_cmd.rate_store) begin
            r_wrate[axis] <= rate_val;
        end
        if (i_cmd.emit_cal) begin
            r_okind <= r_fail ? KIND_FAIL : KIND_PASS;
            r_odata <= '0;
        end else if (i_cmd.emit_run) begin
            r_okind <= KIND_SAMPLE;
            r_odata <= OUT_TDATA_W'({r_wrate[2], r_wrate[1], r_wrate[0],
                                     r_wacc[2], r_wacc[1], r_wacc[0]});
        end
    end

    assign o_sts.running   = r_running;
    assign o_sts.last      = (r_count == CNT_W'(N - 1));
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.div_done  = div_done;
    assign o_sts.smul_done = r_mdone;
    assign o_sts.mean_zero = (r_mean == '0);
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_ovalid;
    assign o_out_tdata = r_odata;
    assign o_out_tuser = r_okind;

endmodule

// ===== rtl/imu_bias_calibrate_and_scale_core.sv =====
// Six-axis IMU calibration and scaling. Each input beat is one raw sample.
// After reset the core calibrates: CAL_SAMPLES samples (a power of two) are
// folded into the accelerometer magnitude sum and the gyro sums and sums of
// squares; the last one produces a status beat (tuser 0 pass, 1 fail and
// restart) with zero data. After a pass every sample produces a corrected
// beat (tuser 2): acceleration over mean magnitude in 1/4096 g and bias-free
// rate in 1/256 deg/s, both saturated. In a calibration sample the shared
// 17x25 multiplier forms six squares, then the 16-step square root runs.
// The last calibration sample adds the mean and the three biases (rounded
// shifts), seven passes of the bit-serial multiplier, three variance tests
// and the emit. A running sample runs the 35-step bit-serial divider, one
// bit a cycle, for each accel axis; with a zero mean magnitude the divide
// is skipped. Input is taken only between samples; a finished beat waits
// in the output register while the next sample is taken. Configuration
// writes belong to idle periods.
module imu_bias_calibrate_and_scale_core #(
    parameter int CAL_SAMPLES = imu_bc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [imu_bc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // accel_x_g, accel_y_g, accel_z_g, rate_x_dps, rate_y_dps, rate_z_dps
    output logic [imu_bc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // result_kind
    output logic [imu_bc_pkg::KIND_W-1:0]       o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [imu_bc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [imu_bc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import imu_bc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    imu_bc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    imu_bc_dp #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_tdata  (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_tdata (o_m_axis_tdata),
        .o_out_tuser (o_m_axis_tuser)
    );

endmodule
